[design/spq_pkg.sv]
// Shared types, widths and codes of the sorted priority queue.
// No dependencies; every other file of the block uses it.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 8;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned PRI_W        = 8;
  localparam int unsigned OCC_W        = 4;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // apply the operation and load the response register
  } spq_cmd_t;

endpackage

[design/spq_if.sv]
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_req_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [spq_pkg::VAL_W-1:0] value;
  logic        [spq_pkg::PRI_W-1:0] priority_req;

  modport source (output valid, kind, value, priority_req, input ready);
  modport sink   (input valid, kind, value, priority_req, output ready);
endinterface

interface spq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                      [1:0]  status;
  logic signed [spq_pkg::VAL_W-1:0] removed_value;
  logic        [spq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, status, removed_value, occupancy, input ready);
  modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

[design/spq_ctrl.sv]
// Controller of the sorted priority queue: request/response handshake FSM.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output spq_pkg::spq_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/spq_datapath.sv]
// Datapath of the sorted priority queue: sorted shift-register slots with a
// per-slot priority compare, fill count and response register. Uses spq_pkg.
module spq_datapath #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  spq_pkg::spq_cmd_t                cmd_i,
  input  logic                             kind_i,
  input  logic signed [spq_pkg::VAL_W-1:0] value_i,
  input  logic        [spq_pkg::PRI_W-1:0] priority_i,
  output logic                      [1:0]  status_o,
  output logic signed [spq_pkg::VAL_W-1:0] removed_value_o,
  output logic        [spq_pkg::OCC_W-1:0] occupancy_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                      kind_q;
  logic [spq_pkg::VAL_W-1:0] val_q;
  logic [spq_pkg::PRI_W-1:0] pri_q;

  logic [spq_pkg::VAL_W-1:0] slot_val_q [CAPACITY];
  logic [spq_pkg::PRI_W-1:0] slot_pri_q [CAPACITY];
  logic [spq_pkg::VAL_W-1:0] slot_val_d [CAPACITY];
  logic [spq_pkg::PRI_W-1:0] slot_pri_d [CAPACITY];
  logic [CAPACITY-1:0]       stay;  // slot holds priority >= new one

  logic [CNT_W-1:0] fill_q, fill_d;
  logic             full, empty, write_slots;
  spq_pkg::status_e status_d;
  logic [spq_pkg::VAL_W-1:0] removed_d;

  assign full  = (fill_q == CNT_W'(CAPACITY));
  assign empty = (fill_q == '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign stay[i] = (fill_q > CNT_W'(i)) && (slot_pri_q[i] >= pri_q);

    always_comb begin
      slot_val_d[i] = slot_val_q[i];
      slot_pri_d[i] = slot_pri_q[i];
      if (kind_q == spq_pkg::KIND_DEQ) begin
        if (i + 1 < CAPACITY) begin
          slot_val_d[i] = slot_val_q[(i + 1) % CAPACITY];
          slot_pri_d[i] = slot_pri_q[(i + 1) % CAPACITY];
        end
      end else if (!stay[i]) begin
        // first non-staying slot takes the new entry, later ones shift down
        if (i == 0 || stay[(i + CAPACITY - 1) % CAPACITY]) begin
          slot_val_d[i] = val_q;
          slot_pri_d[i] = pri_q;
        end else begin
          slot_val_d[i] = slot_val_q[(i + CAPACITY - 1) % CAPACITY];
          slot_pri_d[i] = slot_pri_q[(i + CAPACITY - 1) % CAPACITY];
        end
      end
    end
  end

  always_comb begin
    fill_d      = fill_q;
    status_d    = spq_pkg::ST_DONE;
    removed_d   = '0;
    write_slots = 1'b0;
    if (kind_q == spq_pkg::KIND_ENQ) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        write_slots = 1'b1;
        fill_d      = fill_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        write_slots = 1'b1;
        removed_d   = slot_val_q[0];
        fill_d      = fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      val_q  <= value_i;
      pri_q  <= priority_i;
    end
    if (cmd_i.exec) begin
      status_o        <= status_d;
      removed_value_o <= removed_d;
      occupancy_o     <= spq_pkg::OCC_W'(fill_d);
    end
    if (cmd_i.exec && write_slots) begin
      slot_val_q <= slot_val_d;
      slot_pri_q <= slot_pri_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.exec) begin
      fill_q <= fill_d;
    end
  end

endmodule

[design/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_datapath.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------
//  req_i   | in  | valid/ready | kind, value, priority_req
//  rsp_o   | out | valid/ready | status, removed_value, occupancy
//
// The controller accepts each request, then sorts it into the shift-register
// slots (every slot compares against the new priority at once).
// The response sits in an output register: the next request is accepted
// while a response waits, and execution holds until that register frees.
// Reset clears the fill count and handshake state; slot contents are left
// as they are, and only slots below the fill count are ever read.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  spq_pkg::spq_cmd_t cmd;
  logic              req_ready, rsp_valid;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // datapath carries the sorted slots and drives the response payload
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (req_i.kind),
    .value_i         (req_i.value),
    .priority_i      (req_i.priority_req),
    .status_o        (rsp_o.status),
    .removed_value_o (rsp_o.removed_value),
    .occupancy_o     (rsp_o.occupancy)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

endmodule

[design/spq_checker.sv]
// Port-level assertions for the sorted priority queue, bound to the top.
// Depends on spq_pkg and sorted_priority_queue_unit.
module spq_checker #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic               [1:0]  rsp_status_i,
  input logic [spq_pkg::VAL_W-1:0] rsp_removed_i,
  input logic [spq_pkg::OCC_W-1:0] rsp_occupancy_i
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_removed_i) && $stable(rsp_occupancy_i))
    else $error("stalled response changed");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == spq_pkg::ST_FULL |->
      rsp_occupancy_i == spq_pkg::OCC_W'(CAPACITY) && rsp_removed_i == '0)
    else $error("full rejection with wrong occupancy");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == spq_pkg::ST_EMPTY |->
      rsp_occupancy_i == '0 && rsp_removed_i == '0)
    else $error("empty dequeue with nonzero fields");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_removed_i   (rsp_o.removed_value),
  .rsp_occupancy_i (rsp_o.occupancy)
);
